// ===== hw/rtl/wsp_pkg.sv =====
package wsp_pkg;

    // Fixed-point and counter sizing
    localparam int FRAC_BITS         = 8;
    localparam int PERIOD_COUNT_BITS = 20;

    // Field widths
    localparam int GAIN_W      = 12;
    localparam int RATE_W      = 16;
    localparam int TARGET_W    = 20;
    localparam int TICKS_W     = 11;
    localparam int TOTAL_W     = 32;
    localparam int POWER_OUT_W = 8;
    localparam int CFG_DATA_W  = 20;
    localparam int CFG_INDEX_W = 3;

    // Limits
    localparam int POWER_LIMIT = 100;
    localparam int POWER_LIM_Q = POWER_LIMIT * (2 ** FRAC_BITS);
    localparam int READ_MAX    = (2 ** (TICKS_W - 1)) - 1;

    // Serial multiplier sizing
    localparam int MP_W  = (PERIOD_COUNT_BITS > GAIN_W) ? PERIOD_COUNT_BITS : GAIN_W;
    localparam int CNT_W = $clog2(MP_W + 1);
    localparam int MC_W  = (((PERIOD_COUNT_BITS + RATE_W) > (TOTAL_W + FRAC_BITS)) ?
                            (PERIOD_COUNT_BITS + RATE_W) : (TOTAL_W + FRAC_BITS)) + 1;
    localparam int ACC_W = MC_W + GAIN_W;
    localparam int SUM_W = ACC_W - FRAC_BITS + 2;
    localparam int PWR_W = FRAC_BITS + 8;

    // Register reset values
    localparam logic [GAIN_W-1:0]   PROP_GAIN_RST   = GAIN_W'(461);
    localparam logic [GAIN_W-1:0]   INTEG_GAIN_RST  = GAIN_W'(13);
    localparam logic [GAIN_W-1:0]   DERIV_GAIN_RST  = GAIN_W'(0);
    localparam logic [RATE_W-1:0]   EXP_RATE_RST    = RATE_W'(0);
    localparam logic [TARGET_W-1:0] TARGET_TICKS_RST = '1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PROP_GAIN     = 3'd0,
        CFG_INTEG_GAIN    = 3'd1,
        CFG_DERIV_GAIN    = 3'd2,
        CFG_EXPECTED_RATE = 3'd3,
        CFG_TARGET_TICKS  = 3'd4
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TRACK,
        ST_POS,
        ST_INTEG,
        ST_PROP,
        ST_DERIV,
        ST_CLAMP,
        ST_APPLY,
        ST_FINISH
    } wsp_state_t;

    typedef struct packed {
        logic [PERIOD_COUNT_BITS-1:0] period_count;
        logic signed [TOTAL_W-1:0]    tick_total;
        logic signed [TICKS_W-1:0]    last_reading;
        logic signed [TICKS_W-1:0]    previous_reading;
    } wsp_track_t;

    typedef struct packed {
        logic                    load;
        logic signed [MC_W-1:0]  mcand;
        logic [MP_W-1:0]         mplier;
        logic [CNT_W-1:0]        nbits;
    } wsp_mul_cmd_t;

    typedef struct packed {
        logic                    busy;
        logic signed [ACC_W-1:0] product;
    } wsp_mul_rsp_t;

endpackage

// ===== hw/rtl/wsp_serial_mul.sv =====
module wsp_serial_mul (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  wsp_pkg::wsp_mul_cmd_t cmd,
    output wsp_pkg::wsp_mul_rsp_t rsp
);
    import wsp_pkg::*;

    // Shift-add multiplier, multiplier word left-aligned, one bit per cycle MSB first
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [MC_W-1:0]  mc_reg, mc_next;
    logic [MP_W-1:0]         mp_reg, mp_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [ACC_W-1:0]        addend;

    always_comb begin
        addend   = mp_reg[MP_W-1] ? ACC_W'(mc_reg) : '0;
        acc_next = acc_reg;
        mc_next  = mc_reg;
        mp_next  = mp_reg;
        cnt_next = cnt_reg;
        if (cmd.load) begin
            acc_next = '0;
            mc_next  = cmd.mcand;
            mp_next  = cmd.mplier;
            cnt_next = cmd.nbits;
        end else if (cnt_reg != '0) begin
            acc_next = (acc_reg <<< 1) + $signed(addend);
            mp_next  = mp_reg << 1;
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        acc_reg <= acc_next;
        mc_reg  <= mc_next;
        mp_reg  <= mp_next;
    end

    assign rsp.busy    = (cnt_reg != '0);
    assign rsp.product = acc_reg;

endmodule

// ===== hw/rtl/wsp_track.sv =====
module wsp_track (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                accept,
    input  logic                                rate_neg,
    input  logic signed [wsp_pkg::TICKS_W-1:0]  ticks,
    output wsp_pkg::wsp_track_t                 trk
);
    import wsp_pkg::*;

    logic [PERIOD_COUNT_BITS-1:0] period_reg, period_next;
    logic signed [TOTAL_W-1:0]    total_reg, total_next;
    logic signed [TICKS_W-1:0]    last_reg, prev_reg;
    logic signed [TICKS_W:0]      neg_wide;
    logic signed [TICKS_W-1:0]    reading;
    logic signed [TOTAL_W:0]      total_wide;

    always_comb begin
        // negate for reverse travel; the most negative count saturates
        neg_wide = -((TICKS_W+1)'(ticks));
        if (!rate_neg) begin
            reading = ticks;
        end else if (neg_wide > (TICKS_W+1)'(READ_MAX)) begin
            reading = TICKS_W'(READ_MAX);
        end else begin
            reading = neg_wide[TICKS_W-1:0];
        end

        total_wide = (TOTAL_W+1)'(total_reg) + (TOTAL_W+1)'(reading);
        if (total_wide > $signed({2'b00, {(TOTAL_W-1){1'b1}}})) begin
            total_next = {1'b0, {(TOTAL_W-1){1'b1}}};
        end else if (total_wide < -$signed({2'b00, {(TOTAL_W-1){1'b1}}})) begin
            total_next = -$signed({1'b0, {(TOTAL_W-1){1'b1}}});
        end else begin
            total_next = total_wide[TOTAL_W-1:0];
        end

        period_next = (period_reg == '1) ? period_reg : period_reg + PERIOD_COUNT_BITS'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= '0;
            total_reg  <= '0;
            last_reg   <= '0;
            prev_reg   <= '0;
        end else if (accept) begin
            period_reg <= period_next;
            total_reg  <= total_next;
            last_reg   <= reading;
            prev_reg   <= last_reg;
        end
    end

    assign trk.period_count     = period_reg;
    assign trk.tick_total       = total_reg;
    assign trk.last_reading     = last_reg;
    assign trk.previous_reading = prev_reg;

endmodule

// ===== hw/rtl/wheel_speed_pid_unit.sv =====
// Wheel speed PID controller, one encoder word in, one drive word out.
//
// Input channel (s_valid/s_ready): one word per control period carrying the
// signed encoder tick count. Output channel (m_valid/m_ready): the drive power
// in whole percent plus the updated, overload and target-reached flags.
// Gains, expected rate and target distance come in through the cfg_we write
// port; write them only while no word is in flight.
//
// Processing: with a nonzero expected rate each word runs through the single
// shift-add multiplier, which retires one bit per cycle and is shared by four
// products in turn: expected position (20 bits), then the integral,
// proportional and derivative gains (12 bits each). A new word is taken only
// after the previous result has been loaded into the output register.
// With a zero expected rate the drive is left alone and the word goes
// straight to the output register.
// A finished result sits in the output register while the next word is
// accepted and processed; only the final write waits if the receiver stalls.
// Reset restores register defaults and clears all tracking state and power.
module wheel_speed_pid_unit (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // configuration write port
    input  logic                                    cfg_we,
    input  logic [wsp_pkg::CFG_INDEX_W-1:0]         cfg_index,
    input  logic [wsp_pkg::CFG_DATA_W-1:0]          cfg_wdata,
    // input channel
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic signed [wsp_pkg::TICKS_W-1:0]      s_encoder_ticks,
    // result channel
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic signed [wsp_pkg::POWER_OUT_W-1:0]  m_motor_power,
    output logic                                    m_drive_updated,
    output logic                                    m_overload,
    output logic                                    m_target_reached
);
    import wsp_pkg::*;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [GAIN_W-1:0]        prop_gain_reg, integ_gain_reg, deriv_gain_reg;
    logic signed [RATE_W-1:0] rate_reg;
    logic [TARGET_W-1:0]      target_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg  <= PROP_GAIN_RST;
            integ_gain_reg <= INTEG_GAIN_RST;
            deriv_gain_reg <= DERIV_GAIN_RST;
            rate_reg       <= EXP_RATE_RST;
            target_reg     <= TARGET_TICKS_RST;
        end else if (cfg_we) begin
            case (cfg_index_t'(cfg_index))
                CFG_PROP_GAIN:     prop_gain_reg  <= cfg_wdata[GAIN_W-1:0];
                CFG_INTEG_GAIN:    integ_gain_reg <= cfg_wdata[GAIN_W-1:0];
                CFG_DERIV_GAIN:    deriv_gain_reg <= cfg_wdata[GAIN_W-1:0];
                CFG_EXPECTED_RATE: rate_reg       <= cfg_wdata[RATE_W-1:0];
                CFG_TARGET_TICKS:  target_reg     <= cfg_wdata[TARGET_W-1:0];
                default: ;  // drop writes to unused indexes
            endcase
        end
    end

    logic rate_zero;
    assign rate_zero = (rate_reg == '0);

    // ---------------------------------------------------------------
    // Tick tracking and the shared serial multiplier
    // ---------------------------------------------------------------
    wsp_state_t   state_reg, state_next;
    wsp_track_t   trk;
    wsp_mul_cmd_t mul_cmd;
    wsp_mul_rsp_t mul_rsp;
    logic         in_accept;

    assign in_accept = s_valid && s_ready;

    wsp_track u_track (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (in_accept),
        .rate_neg (rate_reg[RATE_W-1]),
        .ticks    (s_encoder_ticks),
        .trk      (trk)
    );

    wsp_serial_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (mul_cmd),
        .rsp     (mul_rsp)
    );

    // Multiplicands of the four products
    logic signed [MC_W-1:0] mc_pos, mc_integ, mc_prop, mc_deriv;

    always_comb begin
        mc_pos   = MC_W'(rate_reg);
        // expected position minus travelled distance, both in Q.F
        mc_integ = $signed(mul_rsp.product[MC_W-1:0])
                 - (MC_W'($signed(trk.tick_total)) <<< FRAC_BITS);
        mc_prop  = MC_W'(rate_reg) - (MC_W'($signed(trk.last_reading)) <<< FRAC_BITS);
        mc_deriv = (MC_W'($signed(trk.previous_reading))
                 - MC_W'($signed(trk.last_reading))) <<< FRAC_BITS;
    end

    // ---------------------------------------------------------------
    // Sequencer: next state
    // ---------------------------------------------------------------
    logic out_load;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_valid) state_next = ST_TRACK;
            ST_TRACK:  state_next = rate_zero ? ST_FINISH : ST_POS;
            ST_POS:    if (!mul_rsp.busy) state_next = ST_INTEG;
            ST_INTEG:  if (!mul_rsp.busy) state_next = ST_PROP;
            ST_PROP:   if (!mul_rsp.busy) state_next = ST_DERIV;
            ST_DERIV:  if (!mul_rsp.busy) state_next = ST_CLAMP;
            ST_CLAMP:  state_next = ST_APPLY;
            ST_APPLY:  state_next = ST_FINISH;
            ST_FINISH: if (out_load) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer: control outputs
    // ---------------------------------------------------------------
    logic sum_clear, sum_add, flags_clear, apply_en, clamp_en;

    always_comb begin
        s_ready        = 1'b0;
        mul_cmd.load   = 1'b0;
        mul_cmd.mcand  = mc_pos;
        mul_cmd.mplier = MP_W'(trk.period_count) << (MP_W - PERIOD_COUNT_BITS);
        mul_cmd.nbits  = CNT_W'(PERIOD_COUNT_BITS);
        sum_clear      = 1'b0;
        sum_add        = 1'b0;
        flags_clear    = 1'b0;
        clamp_en       = 1'b0;
        apply_en       = 1'b0;
        out_load       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_TRACK: begin
                flags_clear  = 1'b1;
                sum_clear    = 1'b1;
                mul_cmd.load = !rate_zero;
            end
            ST_POS: begin
                mul_cmd.load   = !mul_rsp.busy;
                mul_cmd.mcand  = mc_integ;
                mul_cmd.mplier = MP_W'(integ_gain_reg) << (MP_W - GAIN_W);
                mul_cmd.nbits  = CNT_W'(GAIN_W);
            end
            ST_INTEG: begin
                sum_add        = !mul_rsp.busy;
                mul_cmd.load   = !mul_rsp.busy;
                mul_cmd.mcand  = mc_prop;
                mul_cmd.mplier = MP_W'(prop_gain_reg) << (MP_W - GAIN_W);
                mul_cmd.nbits  = CNT_W'(GAIN_W);
            end
            ST_PROP: begin
                sum_add        = !mul_rsp.busy;
                mul_cmd.load   = !mul_rsp.busy;
                mul_cmd.mcand  = mc_deriv;
                mul_cmd.mplier = MP_W'(deriv_gain_reg) << (MP_W - GAIN_W);
                mul_cmd.nbits  = CNT_W'(GAIN_W);
            end
            ST_DERIV: begin
                sum_add = !mul_rsp.busy;
            end
            ST_CLAMP: begin
                clamp_en = 1'b1;
            end
            ST_APPLY: begin
                apply_en = 1'b1;
            end
            ST_FINISH: begin
                out_load = !m_valid || m_ready;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ---------------------------------------------------------------
    // Correction sum, clamp and power update
    // ---------------------------------------------------------------
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic signed [PWR_W-1:0] corr_reg, corr_next;
    logic signed [PWR_W-1:0] power_reg, power_next;
    logic                    upd_reg, ovl_reg, reach_reg;
    logic                    ovl_next, reach_next;
    logic signed [PWR_W:0]   psum;
    logic [TOTAL_W-1:0]      total_mag;

    always_comb begin
        // floor shift of each product is an arithmetic drop of F bits
        sum_next = sum_reg + SUM_W'($signed(mul_rsp.product[ACC_W-1:FRAC_BITS]));

        if (sum_reg > SUM_W'(POWER_LIM_Q)) begin
            corr_next = PWR_W'(POWER_LIM_Q);
        end else if (sum_reg < -(SUM_W'(POWER_LIM_Q))) begin
            corr_next = -(PWR_W'(POWER_LIM_Q));
        end else begin
            corr_next = sum_reg[PWR_W-1:0];
        end

        total_mag  = trk.tick_total[TOTAL_W-1] ? TOTAL_W'(-trk.tick_total)
                                               : TOTAL_W'(trk.tick_total);
        reach_next = (total_mag > TOTAL_W'(target_reg));
        psum       = (PWR_W+1)'(power_reg) + (PWR_W+1)'(corr_reg);
        ovl_next   = 1'b0;
        if (reach_next) begin
            power_next = '0;
        end else if (psum > (PWR_W+1)'(POWER_LIM_Q)) begin
            power_next = PWR_W'(POWER_LIM_Q);
            ovl_next   = 1'b1;
        end else if (psum < -((PWR_W+1)'(POWER_LIM_Q))) begin
            power_next = -(PWR_W'(POWER_LIM_Q));
            ovl_next   = 1'b1;
        end else begin
            power_next = psum[PWR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            power_reg <= '0;
            upd_reg   <= 1'b0;
            ovl_reg   <= 1'b0;
            reach_reg <= 1'b0;
        end else if (flags_clear) begin
            upd_reg   <= 1'b0;
            ovl_reg   <= 1'b0;
            reach_reg <= 1'b0;
        end else if (apply_en) begin
            power_reg <= power_next;
            upd_reg   <= 1'b1;
            ovl_reg   <= ovl_next;
            reach_reg <= reach_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (sum_clear) begin
            sum_reg <= '0;
        end else if (sum_add) begin
            sum_reg <= sum_next;
        end
        if (clamp_en) begin
            corr_reg <= corr_next;
        end
    end

    // ---------------------------------------------------------------
    // Output register: whole percent, truncated toward zero
    // ---------------------------------------------------------------
    logic                          pneg;
    logic [PWR_W-1:0]              pmag;
    logic [POWER_OUT_W-1:0]        wmag;
    logic signed [POWER_OUT_W-1:0] whole;
    logic                          m_valid_reg;
    logic signed [POWER_OUT_W-1:0] power_out_reg;
    logic                          upd_out_reg, ovl_out_reg, reach_out_reg;

    always_comb begin
        pneg  = power_reg[PWR_W-1];
        pmag  = pneg ? PWR_W'(-power_reg) : PWR_W'(power_reg);
        wmag  = POWER_OUT_W'(pmag >> FRAC_BITS);
        whole = pneg ? -$signed(wmag) : $signed(wmag);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (out_load) begin
            power_out_reg <= whole;
            upd_out_reg   <= upd_reg;
            ovl_out_reg   <= ovl_reg;
            reach_out_reg <= reach_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_motor_power    = power_out_reg;
    assign m_drive_updated  = upd_out_reg;
    assign m_overload       = ovl_out_reg;
    assign m_target_reached = reach_out_reg;

endmodule

// ===== hw/rtl/wsp_checker.sv =====
module wsp_checker (
    input logic                                    aclk,
    input logic                                    aresetn,
    input logic                                    s_valid,
    input logic                                    s_ready,
    input logic                                    m_valid,
    input logic                                    m_ready,
    input logic signed [wsp_pkg::POWER_OUT_W-1:0]  m_motor_power,
    input logic                                    m_drive_updated,
    input logic                                    m_overload,
    input logic                                    m_target_reached
);
    import wsp_pkg::*;

    // reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word valid after reset");

    // one word in flight: input closes right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input ready right after accept");

    // stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_motor_power)
                                   && $stable(m_overload)))
        else $error("stalled result word changed");

    // reached target forces zero power, no overload, drive recomputed
    a_target_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_target_reached) |-> (m_motor_power == '0 && !m_overload
                                           && m_drive_updated))
        else $error("target reached with nonzero power");

    // power stays within the limit
    a_power_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ($signed(m_motor_power) <= POWER_LIMIT
                     && $signed(m_motor_power) >= -POWER_LIMIT))
        else $error("motor power out of range");

endmodule

bind wheel_speed_pid_unit wsp_checker u_wsp_checker (.*);

// ===== tb/wheel_speed_pid_unit_tb.sv =====
module wheel_speed_pid_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wsp_pkg::*;

    // Give up after this many clocks; the slowest legal run needs far fewer.
    localparam int CYCLE_LIMIT = 2_000_000;
    // Receiver hold-off used to back the block up into its input.
    localparam int HOLD_CYCLES = 1500;
    // Extra clocks run after the last word has drained.
    localparam int TAIL_CYCLES = 80;
    localparam int RANDOM_PHASES = 12;
    localparam int WORDS_PER_PHASE = 150;

    localparam longint PERIOD_MAX = (longint'(1) <<< PERIOD_COUNT_BITS) - 1;
    localparam longint TOTAL_SAT = (longint'(1) <<< (TOTAL_W - 1)) - 1;
    // First register index that maps to nothing; writes there are dropped.
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_FIRST = CFG_INDEX_W'(CFG_TARGET_TICKS + 1);

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct packed {
        logic signed [POWER_OUT_W-1:0] power;
        logic                          updated;
        logic                          overload;
        logic                          reached;
    } drive_word_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [TICKS_W-1:0] s_encoder_ticks = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [POWER_OUT_W-1:0] m_motor_power;
    logic m_drive_updated;
    logic m_overload;
    logic m_target_reached;

    wheel_speed_pid_unit u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_encoder_ticks  (s_encoder_ticks),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_motor_power    (m_motor_power),
        .m_drive_updated  (m_drive_updated),
        .m_overload       (m_overload),
        .m_target_reached (m_target_reached)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Shadow copy of the register file, mirrored on every write.
    logic [GAIN_W-1:0]        kp = PROP_GAIN_RST;
    logic [GAIN_W-1:0]        ki = INTEG_GAIN_RST;
    logic [GAIN_W-1:0]        kd = DERIV_GAIN_RST;
    logic signed [RATE_W-1:0] rate_q = EXP_RATE_RST;
    logic [TARGET_W-1:0]      target = TARGET_TICKS_RST;

    // Shadow copy of the controller state; all of it clears on reset.
    longint periods = 0;
    longint tick_sum = 0;
    longint reading_now = 0;
    longint reading_prev = 0;
    longint power_q = 0;

    logic signed [TICKS_W-1:0] pending_ticks[$];
    drive_word_t               drive_expect[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit rx_hold = 1'b0;
    int n_errors = 0;
    int words_checked = 0;
    int n_updated = 0;
    int n_overload = 0;
    int n_reached = 0;
    int n_settings = 0;
    int cycle_count = 0;

    // Clamp to the +-100 percent window in Q8.8; flag when the limit bites.
    function automatic longint limit_power(input longint v, output bit hit);
        hit = 1'b0;
        if (v > POWER_LIM_Q) begin
            hit = 1'b1;
            return POWER_LIM_Q;
        end
        if (v < -POWER_LIM_Q) begin
            hit = 1'b1;
            return -POWER_LIM_Q;
        end
        return v;
    endfunction

    // Advance the shadow controller by one control period and return the
    // drive word the block must emit for it.
    function automatic drive_word_t advance_drive(input logic signed [TICKS_W-1:0] ticks);
        drive_word_t w;
        longint rate, rd, p_term, i_term, d_term, corr, mag;
        bit ignored, hit;
        w = '0;
        hit = 1'b0;
        rate = longint'(rate_q);
        rd = longint'(ticks);
        if (periods < PERIOD_MAX)
            periods++;
        reading_prev = reading_now;
        // Running backward: flip the count; -1024 saturates to +1023.
        if (rate < 0) begin
            rd = -rd;
            if (rd > READ_MAX)
                rd = READ_MAX;
        end
        reading_now = rd;
        tick_sum += rd;
        if (tick_sum > TOTAL_SAT)
            tick_sum = TOTAL_SAT;
        else if (tick_sum < -TOTAL_SAT)
            tick_sum = -TOTAL_SAT;
        if (rate != 0) begin
            // Each gain product drops its fraction bits with floor rounding.
            p_term = ((rate - (rd <<< FRAC_BITS)) * longint'(kp)) >>> FRAC_BITS;
            i_term = ((periods * rate - (tick_sum <<< FRAC_BITS)) * longint'(ki))
                     >>> FRAC_BITS;
            d_term = (((reading_prev - rd) <<< FRAC_BITS) * longint'(kd)) >>> FRAC_BITS;
            corr = limit_power(p_term + i_term + d_term, ignored);
            w.updated = 1'b1;
            power_q += corr;
            mag = (tick_sum < 0) ? -tick_sum : tick_sum;
            if (longint'(target) < mag) begin
                power_q = 0;
                w.reached = 1'b1;
            end else begin
                power_q = limit_power(power_q, hit);
            end
        end
        w.overload = hit;
        // Signed division truncates toward zero, as the output field wants.
        w.power = POWER_OUT_W'(power_q / (longint'(1) <<< FRAC_BITS));
        return w;
    endfunction

    // Driver: present pending words, predict each one as it is accepted.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                drive_expect.push_back(advance_drive(s_encoder_ticks));
            // Hold valid and payload until accepted; only then pick the next.
            if (!s_valid || s_ready) begin
                if (pending_ticks.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_encoder_ticks <= pending_ticks.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d got %0d", $time, name, exp_v, act_v);
            n_errors++;
        end
    endtask

    // Monitor: compare every accepted result with the oldest prediction.
    always @(posedge aclk) begin
        drive_word_t exp_w;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (drive_expect.size() == 0) begin
                    $display("%0t: unexpected drive word, power %0d", $time, m_motor_power);
                    n_errors++;
                end else begin
                    exp_w = drive_expect.pop_front();
                    check_field("motor_power", exp_w.power, m_motor_power);
                    check_field("drive_updated", exp_w.updated, m_drive_updated);
                    check_field("overload", exp_w.overload, m_overload);
                    check_field("target_reached", exp_w.reached, m_target_reached);
                    words_checked++;
                    n_updated += exp_w.updated;
                    n_overload += exp_w.overload;
                    n_reached += exp_w.reached;
                end
            end
            m_ready <= !rx_hold && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d words still expected", $time, drive_expect.size());
            $display("wheel_speed_pid_unit_tb: errors");
            $finish;
        end
    end

    // Write one register and mirror it in the shadow copy. Unused indexes
    // must leave everything alone.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_PROP_GAIN:     kp = val[GAIN_W-1:0];
            CFG_INTEG_GAIN:    ki = val[GAIN_W-1:0];
            CFG_DERIV_GAIN:    kd = val[GAIN_W-1:0];
            CFG_EXPECTED_RATE: rate_q = val[RATE_W-1:0];
            CFG_TARGET_TICKS:  target = val[TARGET_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_settings(input logic [GAIN_W-1:0] p, input logic [GAIN_W-1:0] i,
                                 input logic [GAIN_W-1:0] d,
                                 input logic signed [RATE_W-1:0] r,
                                 input logic [TARGET_W-1:0] t);
        write_reg(CFG_PROP_GAIN, CFG_DATA_W'(p));
        write_reg(CFG_INTEG_GAIN, CFG_DATA_W'(i));
        write_reg(CFG_DERIV_GAIN, CFG_DATA_W'(d));
        write_reg(CFG_EXPECTED_RATE, CFG_DATA_W'(r));
        write_reg(CFG_TARGET_TICKS, CFG_DATA_W'(t));
        n_settings++;
    endtask

    task automatic set_idle(input idle_mode_t mode);
        case (mode)
            IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SENDER:   begin send_idle_pct = 52; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 52; end
            default:       begin send_idle_pct = 24; recv_stall_pct = 24; end
        endcase
    endtask

    // Block until every word is sent and every prediction has been matched.
    task automatic wait_drained();
        do
            @(negedge aclk);
        while (pending_ticks.size() != 0 || s_valid || drive_expect.size() != 0);
    endtask

    function automatic logic [GAIN_W-1:0] pick_gain(input int typical_max);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            return '0;
        if (roll < 20)
            return '1;
        if (roll < 40)
            return GAIN_W'($urandom);
        return GAIN_W'($urandom_range(0, typical_max));
    endfunction

    // Mostly counts near the commanded rate, with some full-range noise.
    function automatic logic signed [TICKS_W-1:0] make_ticks();
        longint nominal;
        if ($urandom_range(0, 99) < 25)
            return TICKS_W'($urandom);
        nominal = (longint'(rate_q) >>> FRAC_BITS) + longint'($urandom_range(0, 16)) - 8;
        if (nominal > READ_MAX)
            nominal = READ_MAX;
        if (nominal < -READ_MAX - 1)
            nominal = -READ_MAX - 1;
        return TICKS_W'(nominal);
    endfunction

    initial begin : stimulus
        logic signed [RATE_W-1:0] r;
        logic [TARGET_W-1:0] t;
        int roll;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset defaults: zero rate, so state moves but the drive stays put.
        set_idle(IDLE_NONE);
        pending_ticks = '{-1024, 1023, 0, -1};
        wait_drained();

        // Full gains, most negative rate: negation of -1024 saturates.
        load_settings('1, '1, '1, {1'b1, {(RATE_W-1){1'b0}}}, '1);
        set_idle(IDLE_SENDER);
        pending_ticks = '{-1024, 1023, -1024, 0, 5, -1};
        wait_drained();

        // Zero gains, smallest rate, zero target: power forced to zero.
        load_settings('0, '0, '0, RATE_W'(1), '0);
        set_idle(IDLE_RECEIVER);
        pending_ticks = '{3, -3, 0};
        wait_drained();

        // Largest rate; then writes to unused indexes must change nothing.
        load_settings(GAIN_W'(256), '0, GAIN_W'(128), {1'b0, {(RATE_W-1){1'b1}}}, '1);
        for (int k = CFG_SPARE_FIRST; k < 2 ** CFG_INDEX_W; k++)
            write_reg(CFG_INDEX_W'(k), CFG_DATA_W'($urandom));
        set_idle(IDLE_BOTH);
        pending_ticks = '{1023, -1024, 512, 0};
        wait_drained();

        // Back to zero rate after a nonzero one: kept power is reported.
        write_reg(CFG_EXPECTED_RATE, '0);
        pending_ticks = '{7, -7};
        wait_drained();

        // Back-pressure: stall the receiver long enough that s_ready drops
        // while the sender keeps offering words.
        load_settings(PROP_GAIN_RST, INTEG_GAIN_RST, GAIN_W'(64), RATE_W'(10 * 256), '1);
        set_idle(IDLE_NONE);
        for (int n = 0; n < 40; n++)
            pending_ticks.push_back(make_ticks());
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        @(negedge aclk);
        rx_hold = 1'b0;
        wait_drained();

        // Random settings, one per phase, rotating through the idle patterns.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            roll = $urandom_range(0, 99);
            if (roll < 15) begin
                r = '0;
            end else if (roll < 25) begin
                r = $urandom_range(0, 1) ? {1'b1, {(RATE_W-1){1'b0}}}
                                         : {1'b0, {(RATE_W-1){1'b1}}};
            end else begin
                r = RATE_W'($urandom_range(256, 40 * 256));
                if ($urandom_range(0, 1))
                    r = -r;
            end
            roll = $urandom_range(0, 99);
            if (roll < 10)
                t = '0;
            else if (roll < 30)
                t = TARGET_W'($urandom_range(0, 5000));
            else if (roll < 60)
                t = '1;
            else
                t = TARGET_W'($urandom);
            load_settings(pick_gain(600), pick_gain(60), pick_gain(300), r, t);
            set_idle(idle_mode_t'(ph % 4));
            for (int n = 0; n < WORDS_PER_PHASE; n++)
                pending_ticks.push_back(make_ticks());
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("checked %0d drive words over %0d register settings", words_checked,
                 n_settings);
        $display("updated %0d, overload %0d, target reached %0d", n_updated, n_overload,
                 n_reached);
        if (n_errors == 0 && drive_expect.size() == 0) begin
            $display("wheel_speed_pid_unit_tb: clean");
        end else begin
            $display("wheel_speed_pid_unit_tb: errors");
        end
        $finish;
    end

endmodule
